[hw/rtl/nnis_pkg.sv]
`default_nettype none

package nnis_pkg;

   // Field widths
   localparam int COORD_WIDTH = 12;
   localparam int COLOR_WIDTH = 8;
   localparam int PIXEL_WIDTH = 3 * COLOR_WIDTH;
   localparam int SIZE_WIDTH  = 9;
   localparam int ZOOM_WIDTH  = 11;

   // Register port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 11;

   // Frame store geometry defaults
   localparam int DEFAULT_MAX_WIDTH  = 256;
   localparam int DEFAULT_MAX_HEIGHT = 256;

   // Register reset values
   localparam int SOURCE_WIDTH_RESET  = 256;
   localparam int SOURCE_HEIGHT_RESET = 256;
   localparam int ZOOM_RESET          = 100;

   // Coordinate mapping: coord * PERCENT / zoom
   localparam int PERCENT   = 100;
   localparam int NUM_WIDTH = 19;            // holds 4095 * 100
   localparam int QUO_WIDTH = COORD_WIDTH;   // quotient saturates at all ones

   // Destination size: floor(size * zoom / 100) via reciprocal multiply
   localparam int PROD_WIDTH   = SIZE_WIDTH + ZOOM_WIDTH;
   localparam int RECIP_SHIFT  = 27;
   localparam int RECIP_MULT   = ((1 << RECIP_SHIFT) + PERCENT - 1) / PERCENT;
   localparam int RECIP_WIDTH  = 21;
   localparam int SCALED_WIDTH = PROD_WIDTH + RECIP_WIDTH;
   localparam int DEST_WIDTH   = 14;
   localparam int DEST_ALIGN   = 4;

   typedef enum logic {
      ACTION_LOAD,
      ACTION_FETCH
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SOURCE_WIDTH,
      CSR_SOURCE_HEIGHT,
      CSR_ZOOM_PERCENT
   } csr_index_type;

   // One input word as it travels down the pipeline
   typedef struct packed {
      action_type             action;
      logic [COORD_WIDTH-1:0] coord_x;
      logic [COORD_WIDTH-1:0] coord_y;
      logic [PIXEL_WIDTH-1:0] pixel;   // {red, green, blue}
   } item_type;

   // Effective configuration seen by the datapath
   typedef struct packed {
      logic [ZOOM_WIDTH-1:0] zoom;
      logic [SIZE_WIDTH-1:0] width;
      logic [SIZE_WIDTH-1:0] height;
      logic [DEST_WIDTH-1:0] dest_width;
      logic [DEST_WIDTH-1:0] dest_height;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/nnis_csr.sv]
`default_nettype none

module nnis_csr
   import nnis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   localparam int SIZE_MAX     = (1 << SIZE_WIDTH) - 1;
   localparam int WIDTH_LIMIT  = (MAX_WIDTH < SIZE_MAX) ? MAX_WIDTH : SIZE_MAX;
   localparam int HEIGHT_LIMIT = (MAX_HEIGHT < SIZE_MAX) ? MAX_HEIGHT : SIZE_MAX;

   logic [SIZE_WIDTH-1:0]   src_width_ff;
   logic [SIZE_WIDTH-1:0]   src_height_ff;
   logic [ZOOM_WIDTH-1:0]   zoom_ff;
   logic [SIZE_WIDTH-1:0]   width_eff;
   logic [SIZE_WIDTH-1:0]   height_eff;
   logic [ZOOM_WIDTH-1:0]   zoom_eff;
   logic [PROD_WIDTH-1:0]   prod_w_in, prod_w_ff;
   logic [PROD_WIDTH-1:0]   prod_h_in, prod_h_ff;
   logic [SCALED_WIDTH-1:0] scaled_w, scaled_h;
   logic [DEST_WIDTH-1:0]   quot_w_in, quot_w_ff;
   logic [DEST_WIDTH-1:0]   quot_h_in, quot_h_ff;
   logic [DEST_WIDTH-1:0]   dest_w_in, dest_w_ff;
   logic [DEST_WIDTH-1:0]   dest_h_in, dest_h_ff;

   // Writes are always taken
   assign csr_ready = 1'b1;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_WIDTH'(SOURCE_WIDTH_RESET);
         src_height_ff <= SIZE_WIDTH'(SOURCE_HEIGHT_RESET);
         zoom_ff       <= ZOOM_WIDTH'(ZOOM_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_width_ff  <= csr_data[SIZE_WIDTH-1:0];
            CSR_SOURCE_HEIGHT: src_height_ff <= csr_data[SIZE_WIDTH-1:0];
            CSR_ZOOM_PERCENT:  zoom_ff       <= csr_data[ZOOM_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Effective values: zero acts as one, oversize sizes clamp to the store
   always_comb begin
      if (src_width_ff == '0) begin
         width_eff = SIZE_WIDTH'(1);
      end else if (src_width_ff > SIZE_WIDTH'(WIDTH_LIMIT)) begin
         width_eff = SIZE_WIDTH'(WIDTH_LIMIT);
      end else begin
         width_eff = src_width_ff;
      end
      if (src_height_ff == '0) begin
         height_eff = SIZE_WIDTH'(1);
      end else if (src_height_ff > SIZE_WIDTH'(HEIGHT_LIMIT)) begin
         height_eff = SIZE_WIDTH'(HEIGHT_LIMIT);
      end else begin
         height_eff = src_height_ff;
      end
      zoom_eff = (zoom_ff == '0) ? ZOOM_WIDTH'(1) : zoom_ff;
   end

   // Destination size, three registered steps: product, /100, round up to 4
   assign prod_w_in = PROD_WIDTH'(width_eff) * PROD_WIDTH'(zoom_eff);
   assign prod_h_in = PROD_WIDTH'(height_eff) * PROD_WIDTH'(zoom_eff);
   assign scaled_w  = SCALED_WIDTH'(prod_w_ff) * SCALED_WIDTH'(RECIP_MULT);
   assign scaled_h  = SCALED_WIDTH'(prod_h_ff) * SCALED_WIDTH'(RECIP_MULT);
   assign quot_w_in = scaled_w[RECIP_SHIFT +: DEST_WIDTH];
   assign quot_h_in = scaled_h[RECIP_SHIFT +: DEST_WIDTH];
   assign dest_w_in = (quot_w_ff + DEST_WIDTH'(DEST_ALIGN - 1)) & ~DEST_WIDTH'(DEST_ALIGN - 1);
   assign dest_h_in = (quot_h_ff + DEST_WIDTH'(DEST_ALIGN - 1)) & ~DEST_WIDTH'(DEST_ALIGN - 1);

   always_ff @(posedge clock) begin
      prod_w_ff <= prod_w_in;
      prod_h_ff <= prod_h_in;
      quot_w_ff <= quot_w_in;
      quot_h_ff <= quot_h_in;
      dest_w_ff <= dest_w_in;
      dest_h_ff <= dest_h_in;
   end

   assign cfg.zoom        = zoom_eff;
   assign cfg.width       = width_eff;
   assign cfg.height      = height_eff;
   assign cfg.dest_width  = dest_w_ff;
   assign cfg.dest_height = dest_h_ff;

endmodule

`default_nettype wire

[hw/rtl/nnis_div.sv]
`default_nettype none

module nnis_div
   import nnis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  item_type              in_item,
   input  logic [ZOOM_WIDTH-1:0] in_zoom,
   output logic                  out_valid,
   input  logic                  out_ready,
   output item_type              out_item,
   output logic [QUO_WIDTH-1:0]  out_quo_x,
   output logic [QUO_WIDTH-1:0]  out_quo_y
);

   // Stage 0 forms coord*100, stages 1..STEPS resolve one quotient bit each
   localparam int STEPS     = QUO_WIDTH;
   localparam int LANES     = 2;
   localparam int CMP_WIDTH = ZOOM_WIDTH + QUO_WIDTH;

   logic [STEPS:0]        valid_ff;
   logic [STEPS+1:0]      advance;
   item_type              item_ff [0:STEPS];
   logic [ZOOM_WIDTH-1:0] zoom_ff [0:STEPS];
   logic [NUM_WIDTH-1:0]  rem_ff  [0:STEPS][0:LANES-1];
   logic [QUO_WIDTH-1:0]  quo_ff  [0:STEPS][0:LANES-1];
   logic                  sat_ff  [0:STEPS][0:LANES-1];

   // A stage takes a word when it is empty or its word moves on
   assign advance[STEPS+1] = out_ready;
   assign in_ready         = advance[0];

   for (genvar s = 0; s <= STEPS; s++) begin : g_stage
      assign advance[s] = !valid_ff[s] || advance[s+1];

      if (s == 0) begin : g_entry
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance[s]) begin
               valid_ff[s] <= in_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (advance[s]) begin
               item_ff[s] <= in_item;
               zoom_ff[s] <= in_zoom;
            end
         end

         for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [COORD_WIDTH-1:0] coord;
            assign coord = (l == 0) ? in_item.coord_x : in_item.coord_y;

            // Numerator coord * 100
            always_ff @(posedge clock) begin
               if (advance[s]) begin
                  rem_ff[s][l] <= NUM_WIDTH'(coord) * NUM_WIDTH'(PERCENT);
                  quo_ff[s][l] <= '0;
                  sat_ff[s][l] <= 1'b0;
               end
            end
         end
      end else begin : g_step
         localparam int STEP_BIT = STEPS - s;

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end

         always_ff @(posedge clock) begin
            if (advance[s]) begin
               item_ff[s] <= item_ff[s-1];
               zoom_ff[s] <= zoom_ff[s-1];
            end
         end

         for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [CMP_WIDTH-1:0] rem_ext;
            logic [CMP_WIDTH-1:0] step_dvs;
            logic                 fits;
            logic                 sat_in;
            logic [NUM_WIDTH-1:0] rem_in;
            logic [QUO_WIDTH-1:0] quo_in;

            // Restoring step; first step also flags quotients past all ones
            always_comb begin
               rem_ext  = CMP_WIDTH'(rem_ff[s-1][l]);
               step_dvs = CMP_WIDTH'(zoom_ff[s-1]) << STEP_BIT;
               fits     = rem_ext >= step_dvs;
               rem_in   = fits ? NUM_WIDTH'(rem_ext - step_dvs) : rem_ff[s-1][l];
               quo_in   = quo_ff[s-1][l];
               quo_in[STEP_BIT] = fits;
               if (s == 1) begin
                  sat_in = rem_ext >= (CMP_WIDTH'(zoom_ff[s-1]) << STEPS);
               end else begin
                  sat_in = sat_ff[s-1][l];
               end
            end

            always_ff @(posedge clock) begin
               if (advance[s]) begin
                  rem_ff[s][l] <= rem_in;
                  quo_ff[s][l] <= quo_in;
                  sat_ff[s][l] <= sat_in;
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_item  = item_ff[STEPS];
   assign out_quo_x = sat_ff[STEPS][0] ? '1 : quo_ff[STEPS][0];
   assign out_quo_y = sat_ff[STEPS][1] ? '1 : quo_ff[STEPS][1];

`ifndef ASSERT_OFF
   // Remainder stays below the divisor weight of the bits still to come
   for (genvar s = 1; s <= STEPS; s++) begin : g_chk
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         a_rem_bound: assert property (@(posedge clock) disable iff (reset)
            valid_ff[s] && !sat_ff[s][l] |->
               CMP_WIDTH'(rem_ff[s][l]) < (CMP_WIDTH'(zoom_ff[s]) << (STEPS - s)))
            else $error("divider remainder out of bound");
      end
   end
`endif

endmodule

`default_nettype wire

[hw/rtl/nnis_store.sv]
`default_nettype none

module nnis_store
   import nnis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  item_type               in_item,
   input  logic [QUO_WIDTH-1:0]   in_quo_x,
   input  logic [QUO_WIDTH-1:0]   in_quo_y,
   input  cfg_type                cfg,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIXEL_WIDTH-1:0] rsp_pixel,
   output logic                   rsp_beyond
);

   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_WIDTH = $clog2(DEPTH);
   localparam int LIM_WIDTH  = COORD_WIDTH + 1;

   // Clamp stage
   logic                   c1_valid_ff;
   action_type             c1_action_ff;
   logic [COORD_WIDTH-1:0] c1_col_in, c1_col_ff;
   logic [COORD_WIDTH-1:0] c1_row_in, c1_row_ff;
   logic                   c1_beyond_in, c1_beyond_ff;
   logic                   c1_wr_ok_in, c1_wr_ok_ff;
   logic [PIXEL_WIDTH-1:0] c1_pixel_ff;

   // Address stage
   logic                   c2_valid_ff;
   action_type             c2_action_ff;
   logic [ADDR_WIDTH-1:0]  c2_addr_in, c2_addr_ff;
   logic                   c2_beyond_ff;
   logic                   c2_wr_ok_ff;
   logic [PIXEL_WIDTH-1:0] c2_pixel_ff;

   // Read data / output register
   logic                   rsp_valid_ff;
   logic                   rsp_beyond_ff;
   logic [PIXEL_WIDTH-1:0] rd_data_ff;

   logic [PIXEL_WIDTH-1:0] frame_mem [0:DEPTH-1];

   logic r_advance, c2_advance, c1_advance;

   assign r_advance  = !rsp_valid_ff || rsp_ready;
   assign c2_advance = !c2_valid_ff || r_advance;
   assign c1_advance = !c1_valid_ff || c2_advance;
   assign in_ready   = c1_advance;

   // Loads use the raw coordinate, fetches the clamped quotient
   always_comb begin
      c1_wr_ok_in  = 1'b0;
      c1_beyond_in = 1'b0;
      if (in_item.action == ACTION_LOAD) begin
         c1_col_in   = in_item.coord_x;
         c1_row_in   = in_item.coord_y;
         c1_wr_ok_in = ({1'b0, in_item.coord_x} < LIM_WIDTH'(MAX_WIDTH)) &&
                       ({1'b0, in_item.coord_y} < LIM_WIDTH'(MAX_HEIGHT));
      end else begin
         c1_col_in = (in_quo_x >= COORD_WIDTH'(cfg.width)) ?
                     COORD_WIDTH'(cfg.width - SIZE_WIDTH'(1)) : in_quo_x;
         c1_row_in = (in_quo_y >= COORD_WIDTH'(cfg.height)) ?
                     COORD_WIDTH'(cfg.height - SIZE_WIDTH'(1)) : in_quo_y;
         c1_beyond_in = (DEST_WIDTH'(in_item.coord_x) >= cfg.dest_width) ||
                        (DEST_WIDTH'(in_item.coord_y) >= cfg.dest_height);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else if (c1_advance) begin
         c1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (c1_advance) begin
         c1_action_ff <= in_item.action;
         c1_col_ff    <= c1_col_in;
         c1_row_ff    <= c1_row_in;
         c1_beyond_ff <= c1_beyond_in;
         c1_wr_ok_ff  <= c1_wr_ok_in;
         c1_pixel_ff  <= in_item.pixel;
      end
   end

   // Linear address row * MAX_WIDTH + col
   assign c2_addr_in = ADDR_WIDTH'(c1_row_ff) * ADDR_WIDTH'(MAX_WIDTH) + ADDR_WIDTH'(c1_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_valid_ff <= 1'b0;
      end else if (c2_advance) begin
         c2_valid_ff <= c1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c2_advance) begin
         c2_action_ff <= c1_action_ff;
         c2_addr_ff   <= c2_addr_in;
         c2_beyond_ff <= c1_beyond_ff;
         c2_wr_ok_ff  <= c1_wr_ok_ff;
         c2_pixel_ff  <= c1_pixel_ff;
      end
   end

   // Frame store: at most one access per word, write for an in-range load, read for fetch
   always_ff @(posedge clock) begin
      if (r_advance && c2_valid_ff) begin
         if (c2_wr_ok_ff) begin
            frame_mem[c2_addr_ff] <= c2_pixel_ff;
         end
         if (c2_action_ff == ACTION_FETCH) begin
            rd_data_ff <= frame_mem[c2_addr_ff];
         end
      end
   end

   // Only fetches produce a result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (r_advance) begin
         rsp_valid_ff <= c2_valid_ff && (c2_action_ff == ACTION_FETCH);
      end
   end

   always_ff @(posedge clock) begin
      if (r_advance) begin
         rsp_beyond_ff <= c2_beyond_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pixel  = rd_data_ff;
   assign rsp_beyond = rsp_beyond_ff;

`ifndef ASSERT_OFF
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      r_advance && c2_valid_ff && (c2_action_ff == ACTION_LOAD) |=> !rsp_valid_ff)
      else $error("load word produced a result");

   a_fetch_clamped: assert property (@(posedge clock) disable iff (reset)
      c1_valid_ff && (c1_action_ff == ACTION_FETCH) |->
         ({1'b0, c1_col_ff} < LIM_WIDTH'(MAX_WIDTH)) &&
         ({1'b0, c1_row_ff} < LIM_WIDTH'(MAX_HEIGHT)))
      else $error("fetch coordinate not clamped into the store");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      c2_valid_ff && ((c2_action_ff == ACTION_FETCH) || c2_wr_ok_ff) |->
         {1'b0, c2_addr_ff} < (ADDR_WIDTH + 1)'(DEPTH))
      else $error("frame store address out of range");
`endif

endmodule

`default_nettype wire

[hw/rtl/nearest_neighbor_image_scaler.sv]
// Nearest-neighbor image scaler for 24-bit BGR pixels.
// Input words (req_*) either load a source pixel into the frame store
// (req_action = 0) or fetch a destination pixel (req_action = 1). A fetch
// maps (x, y) to source (x*100/zoom, y*100/zoom), clamped to the source
// size, and returns that pixel on rsp_*, with rsp_beyond_frame set when
// (x, y) lies past the destination size rounded up to a multiple of 4.
// Loads return nothing. Registers (csr_*): 0 source width, 1 source
// height, 2 zoom percent; write them only while no word is in flight.
// Throughput: one word per cycle while req_ready is high. rsp_valid of
// a fetch is registered through the numerator stage, the 12-stage
// quotient pipeline and the clamp, address and frame store read stages.
// Destination size follows writes via product, quotient and round regs.
// Reset restores 256 x 256 at 100 percent and empties the pipeline; the
// frame store is not cleared and must be loaded before it is fetched.
// When rsp_ready is low the result holds and the pipeline keeps filling
// its empty stages; req_ready drops only once all 16 stages are full.
`default_nettype none

module nearest_neighbor_image_scaler
   import nnis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic [COORD_WIDTH-1:0]     req_coord_x,
   input  logic [COORD_WIDTH-1:0]     req_coord_y,
   input  logic [COLOR_WIDTH-1:0]     req_in_blue,
   input  logic [COLOR_WIDTH-1:0]     req_in_green,
   input  logic [COLOR_WIDTH-1:0]     req_in_red,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [COLOR_WIDTH-1:0]     rsp_out_blue,
   output logic [COLOR_WIDTH-1:0]     rsp_out_green,
   output logic [COLOR_WIDTH-1:0]     rsp_out_red,
   output logic                       rsp_beyond_frame,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type                cfg;
   item_type               req_item;
   item_type               div_item;
   logic                   div_valid;
   logic                   div_ready;
   logic [QUO_WIDTH-1:0]   div_quo_x;
   logic [QUO_WIDTH-1:0]   div_quo_y;
   logic [PIXEL_WIDTH-1:0] rsp_pixel;

   // Pack the input word
   assign req_item.action  = action_type'(req_action);
   assign req_item.coord_x = req_coord_x;
   assign req_item.coord_y = req_coord_y;
   assign req_item.pixel   = {req_in_red, req_in_green, req_in_blue};

   nnis_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   nnis_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .in_zoom   (cfg.zoom),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item),
      .out_quo_x (div_quo_x),
      .out_quo_y (div_quo_y)
   );

   nnis_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_item    (div_item),
      .in_quo_x   (div_quo_x),
      .in_quo_y   (div_quo_y),
      .cfg        (cfg),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pixel  (rsp_pixel),
      .rsp_beyond (rsp_beyond_frame)
   );

   // Unpack the result word
   assign rsp_out_blue  = rsp_pixel[0 +: COLOR_WIDTH];
   assign rsp_out_green = rsp_pixel[COLOR_WIDTH +: COLOR_WIDTH];
   assign rsp_out_red   = rsp_pixel[2*COLOR_WIDTH +: COLOR_WIDTH];

endmodule

`default_nettype wire
